@@ design/swmv_pkg.sv @@
package swmv_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int ACC_W     = 32;
   localparam int DIV_W     = 32;
   localparam int DIV_CNT_W = 6;
   localparam int FACTOR_W  = 19;
   localparam int PROD_W    = 35;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_AVG_LOAD,
      ST_AVG_DIV,
      ST_AVG_FIN,
      ST_MUL,
      ST_ACC,
      ST_WALK,
      ST_VAR_LOAD,
      ST_VAR_DIV,
      ST_EMIT
   } state_type;

endpackage

@@ design/sliding_window_mean_variance.sv @@
// Sliding window mean and variance over the last WINDOW signed 16-bit samples,
// kept in a one-port-read synchronous ring memory. Each word on req returns one
// word on rsp: the truncated average, the incremental variance sum (updated only
// while variance_enable is set) and, once the window is full, the exact windowed
// variance. One word is processed at a time: a new req word is taken only after
// the last one has been emitted. While the window fills, the average comes from
// the one-bit-per-cycle divider that divides the sum by the fill count. Once the
// window is full, both divisions by WINDOW are reciprocal multiplications, and
// the window variance takes a walk over the window through the single memory
// read port. A finished word waits in the output register while the next req
// word is taken. Memory entries need no clearing after reset.
module sliding_window_mean_variance #(
   parameter int WINDOW = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [swmv_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [swmv_pkg::SAMPLE_W-1:0]   rsp_average,
   output logic        [swmv_pkg::ACC_W-1:0]      rsp_running_variance_sum,
   output logic        [swmv_pkg::ACC_W-1:0]      rsp_window_variance,
   output logic                                   rsp_window_full,
   input  logic                                   csr_wr_en,
   input  logic                                   csr_variance_enable
);
   import swmv_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int WALK_W = $clog2(WINDOW + 2);

   // reciprocal constants for division by WINDOW
   localparam int DIV_SH = $clog2(WINDOW);
   localparam int HALF_W = ACC_W / 2;
   localparam int RA_SH  = SUM_W + DIV_SH;
   localparam int RA_W   = SUM_W + 2;
   localparam int AP_W   = SUM_W + RA_W;
   localparam int RV_SH  = ACC_W + DIV_SH;
   localparam int RV_W   = ACC_W + 2;
   localparam int VP_W   = HALF_W + RV_W;
   localparam int VQ_W   = VP_W + HALF_W;
   localparam logic [RA_W-1:0] RA_K = RA_W'(((64'd1 << RA_SH) / 64'(WINDOW)) + 64'd1);
   localparam logic [RV_W-1:0] RV_K = RV_W'(((64'd1 << RV_SH) / 64'(WINDOW)) + 64'd1);

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] window_mem [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                mem_re, mem_we;
   logic [SLOT_W-1:0]   rd_addr;
   logic                emit;

   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;
   logic signed [SAMPLE_W-1:0] prev_avg_ff, prev_avg_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_W-1:0] oldest_ff, oldest_in;
   logic signed [SAMPLE_W-1:0] delta_ff, delta_in;
   logic                       full_ff, full_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [ACC_W-1:0]           var_acc_ff, var_acc_in;
   logic                       var_en_ff, var_en_in;

   logic [DIV_W-1:0]     div_q_ff, div_q_in;
   logic [CNT_W-1:0]     div_r_ff, div_r_in;
   logic [CNT_W-1:0]     div_d_ff, div_d_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic [WALK_W-1:0] walk_cnt_ff, walk_cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              sq_vld_ff, sq_vld_in;
   logic [ACC_W-1:0]  sq_ff, sq_in;
   logic [ACC_W-1:0]  wsum_ff, wsum_in;
   logic [VP_W-1:0]   var_lo_ff, var_lo_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [ACC_W-1:0]           rsp_rvs_ff, rsp_rvs_in;
   logic [ACC_W-1:0]           rsp_wvar_ff, rsp_wvar_in;
   logic                       rsp_full_ff, rsp_full_in;

   // datapath helpers
   logic                       now_full;
   logic [CNT_W:0]             r_shift;
   logic [CNT_W:0]             r_sub;
   logic                       r_ge;
   logic [SUM_W-1:0]           sum_mag;
   logic [SUM_W-1:0]           quo_signed;
   logic signed [FACTOR_W-1:0] factor;
   logic signed [PROD_W-1:0]   prod_neg;
   logic [SAMPLE_W-1:0]        dev;
   logic [SAMPLE_W-1:0]        dev_mag;
   logic [AP_W-1:0]            avg_prod;
   logic [AP_W-1:0]            avg_recip;
   logic [VP_W-1:0]            var_hi;
   logic [VQ_W-1:0]            var_prod;
   logic [VQ_W-1:0]            var_recip;

   assign now_full = (fill_ff == CNT_W'(WINDOW));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_SUM;
         ST_SUM:      state_in = ST_AVG_LOAD;
         ST_AVG_LOAD: state_in = full_ff ? ST_AVG_FIN : ST_AVG_DIV;
         ST_AVG_DIV:  if (div_cnt_ff == DIV_CNT_W'(1)) state_in = ST_AVG_FIN;
         ST_AVG_FIN:  state_in = ST_MUL;
         ST_MUL:      state_in = ST_ACC;
         ST_ACC:      state_in = now_full ? ST_WALK : ST_EMIT;
         ST_WALK:     if (walk_cnt_ff == WALK_W'(WINDOW + 1)) state_in = ST_VAR_LOAD;
         ST_VAR_LOAD: state_in = ST_VAR_DIV;
         ST_VAR_DIV:  state_in = ST_EMIT;
         ST_EMIT:     if (emit) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      rd_addr   = walk_cnt_ff[SLOT_W-1:0];
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            mem_re    = req_valid;
            rd_addr   = slot_ff;
         end
         ST_SUM:  mem_we = 1'b1;
         ST_WALK: mem_re = (walk_cnt_ff < WALK_W'(WINDOW));
         ST_EMIT: emit = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (mem_we) window_mem[slot_ff] <= sample_ff;
      if (mem_re) rd_data_ff <= window_mem[rd_addr];
   end

   // restoring divider step, fill count divisor
   assign r_shift = {div_r_ff, div_q_ff[DIV_W-1]};
   assign r_sub   = r_shift - {1'b0, div_d_ff};
   assign r_ge    = (r_shift >= {1'b0, div_d_ff});

   // division by WINDOW through reciprocal multiplication
   assign avg_prod  = AP_W'(sum_mag) * AP_W'(RA_K);
   assign avg_recip = avg_prod >> RA_SH;
   assign var_hi    = VP_W'(wsum_ff[ACC_W-1:HALF_W]) * VP_W'(RV_K);
   assign var_prod  = {var_hi, {HALF_W{1'b0}}} + VQ_W'(var_lo_ff);
   assign var_recip = var_prod >> RV_SH;

   assign sum_mag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign quo_signed = sum_ff[SUM_W-1] ? (SUM_W'(0) - div_q_ff[SUM_W-1:0])
                                       : div_q_ff[SUM_W-1:0];
   assign factor = full_ff ? (FACTOR_W'(sample_ff) + FACTOR_W'(oldest_ff)
                              - FACTOR_W'(prev_avg_ff) - FACTOR_W'(avg_ff))
                           : (FACTOR_W'(sample_ff) - FACTOR_W'(avg_ff));
   assign prod_neg = -prod_ff;
   assign dev      = rd_data_ff - avg_ff;
   assign dev_mag  = dev[SAMPLE_W-1] ? (SAMPLE_W'(0) - dev) : dev;

   always_comb begin
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      avg_in      = avg_ff;
      prev_avg_in = prev_avg_ff;
      sample_in   = sample_ff;
      oldest_in   = oldest_ff;
      delta_in    = delta_ff;
      full_in     = full_ff;
      prod_in     = prod_ff;
      var_acc_in  = var_acc_ff;
      div_q_in    = div_q_ff;
      div_r_in    = div_r_ff;
      div_d_in    = div_d_ff;
      div_cnt_in  = div_cnt_ff;
      walk_cnt_in = walk_cnt_ff;
      wsum_in     = wsum_ff;
      var_lo_in   = var_lo_ff;
      var_en_in   = csr_wr_en ? csr_variance_enable : var_en_ff;
      rd_vld_in   = (state_ff == ST_WALK) && mem_re;
      sq_vld_in   = rd_vld_ff;
      sq_in       = ACC_W'(dev_mag) * ACC_W'(dev_mag);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) sample_in = req_sample;
         end
         ST_SUM: begin
            oldest_in   = rd_data_ff;
            prev_avg_in = avg_ff;
            full_in     = now_full;
            slot_in     = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            if (now_full) begin
               delta_in = sample_ff - $signed(rd_data_ff);
               sum_in   = sum_ff + SUM_W'(sample_ff) - SUM_W'($signed(rd_data_ff));
            end else begin
               delta_in = sample_ff - avg_ff;
               sum_in   = sum_ff + SUM_W'(sample_ff);
               fill_in  = fill_ff + 1'b1;
            end
         end
         ST_AVG_LOAD: begin
            if (full_ff) begin
               div_q_in = DIV_W'(avg_recip[SUM_W-1:0]);
            end else begin
               div_q_in   = {sum_mag, {(DIV_W - SUM_W){1'b0}}};
               div_r_in   = '0;
               div_d_in   = fill_ff;
               div_cnt_in = DIV_CNT_W'(SUM_W);
            end
         end
         ST_AVG_DIV: begin
            div_q_in   = {div_q_ff[DIV_W-2:0], r_ge};
            div_r_in   = r_ge ? r_sub[CNT_W-1:0] : r_shift[CNT_W-1:0];
            div_cnt_in = div_cnt_ff - 1'b1;
         end
         ST_AVG_FIN: begin
            avg_in = quo_signed[SAMPLE_W-1:0];
         end
         ST_MUL: begin
            prod_in = PROD_W'(factor) * PROD_W'(delta_ff);
         end
         ST_ACC: begin
            if (var_en_ff) begin
               if (full_ff && prod_ff[PROD_W-1] && (prod_neg[ACC_W-1:0] > var_acc_ff))
                  var_acc_in = '0;
               else
                  var_acc_in = var_acc_ff + prod_ff[ACC_W-1:0];
            end
            walk_cnt_in = '0;
            wsum_in     = '0;
         end
         ST_WALK: begin
            walk_cnt_in = walk_cnt_ff + 1'b1;
            if (sq_vld_ff) wsum_in = wsum_ff + sq_ff;
         end
         ST_VAR_LOAD: begin
            var_lo_in = VP_W'(wsum_ff[HALF_W-1:0]) * VP_W'(RV_K);
         end
         ST_VAR_DIV: begin
            div_q_in = var_recip[ACC_W-1:0];
         end
         default: ;
      endcase
   end

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_rvs_in   = rsp_rvs_ff;
      rsp_wvar_in  = rsp_wvar_ff;
      rsp_full_in  = rsp_full_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in   = avg_ff;
         rsp_rvs_in   = var_acc_ff;
         rsp_wvar_in  = now_full ? div_q_ff : '0;
         rsp_full_in  = now_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         var_acc_ff   <= '0;
         var_en_ff    <= 1'b0;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         var_acc_ff   <= var_acc_in;
         var_en_ff    <= var_en_in;
         rd_vld_ff    <= rd_vld_in;
         sq_vld_ff    <= sq_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_avg_ff <= prev_avg_in;
      sample_ff   <= sample_in;
      oldest_ff   <= oldest_in;
      delta_ff    <= delta_in;
      full_ff     <= full_in;
      prod_ff     <= prod_in;
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      div_d_ff    <= div_d_in;
      div_cnt_ff  <= div_cnt_in;
      walk_cnt_ff <= walk_cnt_in;
      sq_ff       <= sq_in;
      wsum_ff     <= wsum_in;
      var_lo_ff   <= var_lo_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_rvs_ff  <= rsp_rvs_in;
      rsp_wvar_ff <= rsp_wvar_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_average              = rsp_avg_ff;
   assign rsp_running_variance_sum = rsp_rvs_ff;
   assign rsp_window_variance      = rsp_wvar_ff;
   assign rsp_window_full          = rsp_full_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_accept_to_sum: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SUM))
      else $error("accepted word did not start update");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AVG_DIV) |-> (div_d_ff != '0 && div_cnt_ff != '0))
      else $error("divider running with zero divisor or count");

   a_var_zero_filling: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_window_full) |-> (rsp_window_variance == '0))
      else $error("window variance nonzero before window full");

   a_walk_only_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> now_full)
      else $error("window walk while filling");

endmodule
